// ----- hw/rtl/mhpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index 2k+2 of the last slot needs two bits above a slot index
  localparam int CH_W     = IDX_W + 2;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_EXTRACT  = 2'd1,
    KIND_PEEK     = 2'd2,
    KIND_DECREASE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_LARGER = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/min_heap_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Binary min-heap priority queue of signed 32-bit keys, up to 64 held in one
// synchronous single-port-read RAM (one write, one read per cycle, read data
// back in the next cycle). Each input word is a request (insert, extract-min,
// peek, decrease-key) and yields exactly one result word: value (the minimum
// for a successful extract or peek, else zero), status and the count after
// the request. One request is worked at a time; the moving key rides in a
// register and slots are shifted into the hole it leaves, so each level of a
// climb costs one RAM read and one write and each level of a sink two reads
// and one write (both children are read through the one read port). The
// result register lets a new request be taken while the previous result still
// waits downstream.
module min_heap_priority_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_kind,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0]  in_key,
  input  wire logic [mhpq_pkg::IDX_W-1:0]         in_position,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [mhpq_pkg::KEY_W-1:0]       out_value,
  output logic [2:0]                              out_status,
  output logic [mhpq_pkg::CNT_W-1:0]              out_count
);

  localparam int IDX_W = mhpq_pkg::IDX_W;
  localparam int CNT_W = mhpq_pkg::CNT_W;
  localparam int CH_W  = mhpq_pkg::CH_W;
  localparam int KEY_W = mhpq_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDROOT,  // root word arriving (extract, peek)
    S_RDLAST,  // last word arriving (extract)
    S_RDPOS,   // word at position arriving (decrease)
    S_UP,      // parent word arriving, climb one level
    S_DNL,     // left child arriving
    S_DNR,     // right child arriving, pick and sink one level
    S_WRK,     // drop the moving key into the hole
    S_FINISH   // hand result to the output register
  } state_t;

  // heap storage
  logic signed [KEY_W-1:0] heap_mem [mhpq_pkg::CAPACITY];
  logic signed [KEY_W-1:0] rdata_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic signed [KEY_W-1:0] mem_wd;
  logic [IDX_W-1:0]        mem_ra;

  // sequencer state
  state_t                  state_r, state_nxt;
  mhpq_pkg::kind_t         kind_r, kind_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;       // hole position
  logic signed [KEY_W-1:0] key_r, key_nxt;       // moving key
  logic signed [KEY_W-1:0] lkey_r, lkey_nxt;     // left child key
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [KEY_W-1:0] res_val_r, res_val_nxt;
  mhpq_pkg::status_t       res_st_r, res_st_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_value_r, out_value_nxt;
  mhpq_pkg::status_t       out_status_r, out_status_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;

  // index arithmetic
  logic [IDX_W-1:0]        tail_idx, tail_par, par, ppar;
  logic [CH_W-1:0]         n_ext, lc, rc, blc;
  logic                    rc_ok, l_lt, r_lt, move;
  logic signed [KEY_W-1:0] sel_key;
  logic [IDX_W-1:0]        sel_idx;

  assign tail_idx = IDX_W'(cnt_r);
  assign tail_par = (tail_idx - IDX_W'(1)) >> 1;
  assign par      = (idx_r - IDX_W'(1)) >> 1;
  assign ppar     = (par - IDX_W'(1)) >> 1;
  assign n_ext    = CH_W'(cnt_r);
  assign lc       = {1'b0, idx_r, 1'b1};
  assign rc       = {1'b0, idx_r, 1'b0} + CH_W'(2);
  assign rc_ok    = rc < n_ext;

  // smallest of hole key, left child and (if present) right child
  always_comb begin
    l_lt    = lkey_r < key_r;
    sel_key = l_lt ? lkey_r : key_r;
    sel_idx = l_lt ? IDX_W'(lc) : idx_r;
    r_lt    = rc_ok && (rdata_r < sel_key);
    move    = l_lt || r_lt;
    if (r_lt) begin
      sel_key = rdata_r;
      sel_idx = IDX_W'(rc);
    end
  end

  assign blc = {1'b0, sel_idx, 1'b1};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= heap_mem[mem_ra];
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    lkey_nxt       = lkey_r;
    cnt_nxt        = cnt_r;
    res_val_nxt    = res_val_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = key_r;
    mem_ra         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = mhpq_pkg::kind_t'(in_kind);
          key_nxt     = in_key;
          res_val_nxt = '0;
          res_st_nxt  = mhpq_pkg::ST_OK;
          case (mhpq_pkg::kind_t'(in_kind))
            mhpq_pkg::KIND_INSERT: begin
              if (cnt_r >= CNT_W'(mhpq_pkg::CAPACITY)) begin
                res_st_nxt = mhpq_pkg::ST_FULL;
                state_nxt  = S_FINISH;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
                idx_nxt = tail_idx;
                if (cnt_r == '0) begin
                  state_nxt = S_WRK;
                end else begin
                  mem_ra    = tail_par;
                  state_nxt = S_UP;
                end
              end
            end
            mhpq_pkg::KIND_EXTRACT, mhpq_pkg::KIND_PEEK: begin
              if (cnt_r == '0) begin
                res_st_nxt = mhpq_pkg::ST_EMPTY;
                state_nxt  = S_FINISH;
              end else begin
                if (in_kind == mhpq_pkg::KIND_EXTRACT) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
                state_nxt = S_RDROOT;
              end
            end
            default: begin
              if (CNT_W'(in_position) >= cnt_r) begin
                res_st_nxt = mhpq_pkg::ST_BADIDX;
                state_nxt  = S_FINISH;
              end else begin
                mem_ra    = in_position;
                idx_nxt   = in_position;
                state_nxt = S_RDPOS;
              end
            end
          endcase
        end
      end

      S_RDROOT: begin
        res_val_nxt = rdata_r;
        if (kind_r == mhpq_pkg::KIND_PEEK || cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          mem_ra    = tail_idx;  // count already lowered: last word
          state_nxt = S_RDLAST;
        end
      end

      S_RDLAST: begin
        key_nxt = rdata_r;
        idx_nxt = '0;
        if (cnt_r == CNT_W'(1)) begin
          mem_we    = 1'b1;
          mem_wa    = '0;
          mem_wd    = rdata_r;
          state_nxt = S_FINISH;
        end else begin
          mem_ra    = IDX_W'(1);
          state_nxt = S_DNL;
        end
      end

      S_RDPOS: begin
        if (key_r > rdata_r) begin
          res_st_nxt = mhpq_pkg::ST_LARGER;
          state_nxt  = S_FINISH;
        end else if (idx_r == '0) begin
          state_nxt = S_WRK;
        end else begin
          mem_ra    = par;
          state_nxt = S_UP;
        end
      end

      S_UP: begin
        mem_we = 1'b1;
        if (rdata_r > key_r) begin
          // parent moves down into the hole
          mem_wd  = rdata_r;
          idx_nxt = par;
          if (par == '0) begin
            state_nxt = S_WRK;
          end else begin
            mem_ra = ppar;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_DNL: begin
        lkey_nxt  = rdata_r;
        mem_ra    = IDX_W'(rc);
        state_nxt = S_DNR;
      end

      S_DNR: begin
        mem_we = 1'b1;
        if (move) begin
          mem_wd  = sel_key;
          idx_nxt = sel_idx;
          if (blc < n_ext) begin
            mem_ra    = IDX_W'(blc);
            state_nxt = S_DNL;
          end else begin
            state_nxt = S_WRK;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_WRK: begin
        mem_we    = 1'b1;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_val_r;
          out_status_nxt = res_st_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    lkey_r       <= lkey_nxt;
    res_val_r    <= res_val_nxt;
    res_st_r     <= res_st_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

// ----- bench/min_heap_priority_queue_test.sv -----
`timescale 1ns / 1ps

module min_heap_priority_queue_test;
  import mhpq_pkg::*;

  // Watchdog: cycles in a row with no word accepted on either side.
  // Worst correct gap is a long extract plus a long run of stalls.
  localparam int STUCK_LIMIT = 3000;
  // Cycles to let pass after the last expected word, past the worst latency.
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PER_PHASE = 170;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } heap_result_t;

  // Tracks the heap contents and the result words still owed by the block.
  class heap_scoreboard;
    logic signed [KEY_W-1:0] keys [CAPACITY];
    int                      held;
    heap_result_t            owed_q [$];
    int                      mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void swap_keys(int a, int b);
      logic signed [KEY_W-1:0] t;
      t       = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
    endfunction

    function void sift_up(int i);
      int up;
      while (i > 0) begin
        up = (i - 1) / 2;
        if (keys[up] <= keys[i]) break;
        swap_keys(up, i);
        i = up;
      end
    endfunction

    function void sift_down(int i);
      int best, lc, rc;
      while (i < held) begin
        best = i;
        lc   = 2 * i + 1;
        rc   = 2 * i + 2;
        if (lc < held && keys[lc] < keys[best]) best = lc;
        if (rc < held && keys[rc] < keys[best]) best = rc;
        if (best == i) break;
        swap_keys(i, best);
        i = best;
      end
    endfunction

    // Apply one accepted request and queue the word it must produce.
    function void note_request(kind_t kind, logic signed [KEY_W-1:0] key,
                               logic [IDX_W-1:0] pos);
      heap_result_t r;
      r.value  = '0;
      r.status = ST_OK;
      case (kind)
        KIND_INSERT: begin
          if (held >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            keys[held] = key;
            held++;
            sift_up(held - 1);
          end
        end
        KIND_EXTRACT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = keys[0];
            held--;
            keys[0] = keys[held];
            sift_down(0);
          end
        end
        KIND_PEEK: begin
          if (held == 0) r.status = ST_EMPTY;
          else r.value = keys[0];
        end
        default: begin
          if (int'(pos) >= held) begin
            r.status = ST_BADIDX;
          end else if (key > keys[pos]) begin
            r.status = ST_LARGER;
          end else begin
            keys[pos] = key;
            sift_up(int'(pos));
          end
        end
      endcase
      r.count = CNT_W'(held);
      owed_q.push_back(r);
    endfunction

    function void check_result(logic signed [KEY_W-1:0] value, logic [2:0] status,
                               logic [CNT_W-1:0] count);
      heap_result_t exp;
      if (owed_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: value %0d status %0d count %0d",
                   value, status, count);
        mismatches++;
      end else begin
        exp = owed_q.pop_front();
        if (value !== exp.value || status !== exp.status || count !== exp.count) begin
          if (mismatches < 10)
            $display("result mismatch: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
                     exp.value, exp.status, exp.count, value, status, count);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_kind = KIND_PEEK;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [IDX_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [KEY_W-1:0] out_value;
  logic [2:0]              out_status;
  logic [CNT_W-1:0]        out_count;

  // Idle percentages for the sender gaps and the receiver stalls, set per phase.
  int send_idle_pct  = 24;
  int recv_stall_pct = 46;
  int stuck_cycles   = 0;

  heap_scoreboard sb = new();

  min_heap_priority_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: take words on the edge, then pick the stall for the next cycle.
  // Values read here are the ones from before the edge, since the block and
  // this bench both update through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_status, out_count);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Present one request word, optionally after a random gap, and hold it until
  // the block takes it. in_valid only gets one nonblocking write per step: it
  // is dropped at the start of a gap and raised a later cycle, or left high.
  task automatic send_request(kind_t kind, logic signed [KEY_W-1:0] key,
                              logic [IDX_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_key      <= key;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kind, key, pos);
  endtask

  // Mix of full-range keys, values near both extremes and a narrow band
  // around zero so that ties show up often.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return KEY_MAX - $urandom_range(3);
      3:       return KEY_MIN + $urandom_range(3);
      default: return int'($urandom_range(200)) - 100;
    endcase
  endfunction

  // New key for a decrease at a live slot: mostly equal or lower, some larger
  // so the reject path is hit, clamped to the key range.
  function automatic logic signed [KEY_W-1:0] pick_decrease_key(int pos);
    longint cur, k;
    cur = sb.keys[pos];
    case ($urandom_range(9))
      0, 1:    k = cur;
      2, 3, 4: k = cur - $urandom_range(1000, 1);
      5:       k = KEY_MIN;
      6:       k = longint'($signed($urandom));
      default: k = cur + $urandom_range(1000, 1);
    endcase
    if (k < KEY_MIN) k = KEY_MIN;
    if (k > KEY_MAX) k = KEY_MAX;
    return KEY_W'(k);
  endfunction

  // Heap-level-driven random traffic: a fill bias grows the heap toward full,
  // a drain bias empties it, and each bias flips at random once the heap sits
  // at its limit so that full inserts and empty extracts keep occurring.
  bit filling = 1'b1;

  task automatic send_random_request();
    int               r;
    kind_t            kind;
    logic [IDX_W-1:0] pos;
    logic signed [KEY_W-1:0] key;
    if (filling && sb.held == CAPACITY && $urandom_range(2) == 0) filling = 1'b0;
    if (!filling && sb.held == 0 && $urandom_range(2) == 0) filling = 1'b1;
    r = $urandom_range(99);
    if (filling)
      kind = (r < 50) ? KIND_INSERT : (r < 65) ? KIND_EXTRACT :
             (r < 75) ? KIND_PEEK : KIND_DECREASE;
    else
      kind = (r < 15) ? KIND_INSERT : (r < 60) ? KIND_EXTRACT :
             (r < 70) ? KIND_PEEK : KIND_DECREASE;
    // mostly a live slot; otherwise any slot, which is often past the end
    if (sb.held > 0 && $urandom_range(9) < 8) pos = IDX_W'($urandom_range(sb.held - 1));
    else pos = IDX_W'($urandom_range(CAPACITY - 1));
    if (kind == KIND_DECREASE && int'(pos) < sb.held) key = pick_decrease_key(int'(pos));
    else key = pick_key();
    send_request(kind, key, pos);
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty heap first, then a small heap with extreme keys.
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_EXTRACT, '0, '0);
    send_request(KIND_DECREASE, 32'sd5, '0);            // bad index on empty heap
    send_request(KIND_INSERT, KEY_MAX, '0);
    send_request(KIND_INSERT, KEY_MIN, 6'd63);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, -32'sd1, '0);
    send_request(KIND_INSERT, '0, '0);                  // duplicate key
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_DECREASE, -32'sd7, 6'd5);         // slot just past the end
    send_request(KIND_DECREASE, -32'sd7, 6'd63);        // top slot, far past the end
    send_request(KIND_DECREASE, KEY_MAX, '0);           // larger than root: rejected
    send_request(KIND_DECREASE, sb.keys[4], 6'd4);      // equal key is accepted
    send_request(KIND_DECREASE, KEY_MIN, 6'd4);         // ties the root on the way up
    send_request(KIND_DECREASE, sb.keys[2] - 1, 6'd2);
    repeat (6) send_request(KIND_EXTRACT, '0, '0);      // last one hits empty
    send_request(KIND_INSERT, 32'sd5, '0);
    send_request(KIND_DECREASE, 32'sd5, '0);
    send_request(KIND_EXTRACT, '0, '0);

    // Random traffic in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 24; recv_stall_pct = 46; end
        1: begin send_idle_pct = 46; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_request();
    end
    in_valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mhpq_pkg.sv
hw/rtl/min_heap_priority_queue.sv
bench/min_heap_priority_queue_test.sv
